// ===== src/zhu_pkg.sv =====
// Shared types and constants of the Zobrist hash update block.
package zhu_pkg;

  // Input action codes.
  localparam logic [1:0] ACTION_LOAD = 2'd0;
  localparam logic [1:0] ACTION_SCAN = 2'd1;
  localparam logic [1:0] ACTION_MOVE = 2'd2;

  // Result kinds.
  localparam logic KIND_BOARD = 1'b0;
  localparam logic KIND_MOVE  = 1'b1;

  // Salt addresses are carried at the width of the largest table (64 x 32).
  localparam int SALT_AW = 11;

  // Decoupling queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PW    = 2;

  // Output buffer depth in the back part.
  localparam int OUT_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_SCAN = 2'd1,
    OP_MOVE = 2'd2
  } zhu_op_kind_t;

  // One classified item: up to three salt reads, compacted to the front.
  typedef struct packed {
    zhu_op_kind_t             act;
    logic [1:0]               nrd;   // number of salt reads, 0..3
    logic                     emit;  // item gives a result
    logic [2:0][SALT_AW-1:0]  addr;  // read addresses, or write address in addr[0]
    logic [63:0]              dlo;   // salt word or old key, low half
    logic [63:0]              dhi;   // salt word or old key, high half
  } zhu_op_t;

  // Queue head as seen by the back part.
  typedef struct packed {
    logic    valid;
    zhu_op_t op;
  } zhu_head_t;

endpackage

// ===== src/zhu_item_if.sv =====
// Input channel interface: one item per beat.
interface zhu_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [8:0]  salt_index;
  logic [63:0] data_low;
  logic [63:0] data_high;
  logic [4:0]  from_square;
  logic [4:0]  to_square;
  logic [3:0]  from_piece;
  logic [3:0]  to_piece;
  logic        empty_flag;
  logic [3:0]  revealed_piece;

  modport source (
    output valid, action, salt_index, data_low, data_high, from_square, to_square,
           from_piece, to_piece, empty_flag, revealed_piece,
    input  ready
  );
  modport sink (
    input  valid, action, salt_index, data_low, data_high, from_square, to_square,
           from_piece, to_piece, empty_flag, revealed_piece,
    output ready
  );
endinterface

// ===== src/zhu_result_if.sv =====
// Output channel interface: one hash key per beat.
interface zhu_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] key_low;
  logic [63:0] key_high;

  modport source (output valid, kind, key_low, key_high, input ready);
  modport sink   (input  valid, kind, key_low, key_high, output ready);
endinterface

// ===== src/zobrist_hash_update.sv =====
// Top level of the 128-bit Zobrist hash update block.
//
//   channel   dir   beat carries
//   -------   ---   -----------------------------------------------------------
//   item      in    action, salt_index, data_low/high, squares, pieces, flags
//   result    out   kind, key_low, key_high
//
// A salt load or a board square uses the salt memory once; a move issues
// one salt read per in-range salt (at most flip 2, plain move 2, capture 3),
// one after another, set by the single read/write port of the salt memory.
// A result passes the queue, the salt read register and the output buffer.
// Reset clears the queue, sequencer, scan key and output buffer; salt
// contents stay unknown until loaded. Items keep flowing while up to two
// results wait on a stalled result channel.
module zobrist_hash_update #(
  parameter int SQUARES     = 32,
  parameter int PIECE_TYPES = 15
) (
  input  logic         clk,
  input  logic         rst,
  zhu_item_if.sink     item,
  zhu_result_if.source result
);
  import zhu_pkg::*;

  // front -> queue
  logic      push;
  zhu_op_t   push_op;
  logic      q_ready;

  // queue -> back
  zhu_head_t head;
  logic      pop;

  // Front classifies every beat: load address check, scan square, or the
  // list of up to three salt reads for a flip, plain move or capture.
  // Unused actions and out-of-range loads are taken and dropped here.
  zhu_front #(
    .SQUARES     (SQUARES),
    .PIECE_TYPES (PIECE_TYPES)
  ) u_front (
    .item    (item),
    .q_ready (q_ready),
    .push    (push),
    .push_op (push_op)
  );

  // Decoupling queue: the front keeps accepting while the back works through
  // the reads of a capture.
  zhu_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .q_ready (q_ready),
    .pop     (pop),
    .head    (head)
  );

  // Back owns the salt memory and accumulates keys, one memory access per
  // cycle unless the queue is empty or its small output buffer has no room.
  zhu_back #(
    .SQUARES     (SQUARES),
    .PIECE_TYPES (PIECE_TYPES)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule

// ===== src/zhu_front.sv =====
// Front part: accepts items, computes salt addresses and range checks.
module zhu_front #(
  parameter int SQUARES     = 32,
  parameter int PIECE_TYPES = 15
) (
  zhu_item_if.sink         item,
  input  logic             q_ready,
  output logic             push,
  output zhu_pkg::zhu_op_t push_op
);
  import zhu_pkg::*;

  localparam int          DEPTH   = SQUARES * PIECE_TYPES;
  localparam logic [15:0] SQ_N    = 16'(SQUARES);
  localparam logic [15:0] PT_N    = 16'(PIECE_TYPES);
  localparam logic [15:0] DEPTH_N = 16'(DEPTH);
  localparam logic [15:0] LAST_SQ = 16'(SQUARES - 1);
  localparam logic [15:0] COVER   = 16'(PIECE_TYPES - 1);

  logic [2:0][4:0]  cand_sq;
  logic [2:0][15:0] cand_pc;
  logic [2:0]       cand_en;
  logic             keep;
  logic [1:0]       n;
  logic [15:0]      full_addr;

  always_comb begin
    push_op      = '0;
    push_op.dlo  = item.data_low;
    push_op.dhi  = item.data_high;
    cand_sq      = '0;
    cand_pc      = '0;
    cand_en      = '0;
    keep         = 1'b1;
    n            = 2'd0;
    full_addr    = '0;
    case (item.action)
      ACTION_LOAD: begin
        push_op.act = OP_LOAD;
        keep        = {7'd0, item.salt_index} < DEPTH_N;
      end
      ACTION_SCAN: begin
        push_op.act  = OP_SCAN;
        push_op.emit = {11'd0, item.from_square} == LAST_SQ;
        cand_sq[0]   = item.from_square;
        cand_pc[0]   = {12'd0, item.from_piece};
        cand_en[0]   = !item.empty_flag;
      end
      ACTION_MOVE: begin
        push_op.act  = OP_MOVE;
        push_op.emit = 1'b1;
        if (item.from_square == item.to_square) begin
          // flip: drop the covered salt, add the revealed piece
          cand_sq[0] = item.from_square;
          cand_pc[0] = COVER;
          cand_en[0] = 1'b1;
          cand_sq[1] = item.from_square;
          cand_pc[1] = {12'd0, item.revealed_piece};
          cand_en[1] = 1'b1;
        end else begin
          cand_sq[0] = item.from_square;
          cand_pc[0] = {12'd0, item.from_piece};
          cand_en[0] = 1'b1;
          cand_sq[1] = item.to_square;
          cand_pc[1] = {12'd0, item.to_piece};
          cand_en[1] = !item.empty_flag;
          cand_sq[2] = item.to_square;
          cand_pc[2] = {12'd0, item.from_piece};
          cand_en[2] = 1'b1;
        end
      end
      default: begin
        push_op.act = OP_SCAN;
        keep        = 1'b0;
      end
    endcase

    // off-board squares or pieces read as a zero salt: just skip them
    for (int i = 0; i < 3; i++) begin
      if (cand_en[i] && ({11'd0, cand_sq[i]} < SQ_N) && (cand_pc[i] < PT_N)) begin
        full_addr        = 16'({11'd0, cand_sq[i]} * PT_N) + cand_pc[i];
        push_op.addr[n]  = full_addr[SALT_AW-1:0];
        n                = n + 2'd1;
      end
    end
    push_op.nrd = n;

    if (item.action == ACTION_LOAD) begin
      push_op.addr[0] = {{(SALT_AW-9){1'b0}}, item.salt_index};
    end
  end

  assign item.ready = q_ready;
  assign push       = item.valid && q_ready && keep;

endmodule

// ===== src/zhu_queue.sv =====
// Short FIFO of classified items between the front and back parts.
module zhu_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  zhu_pkg::zhu_op_t  push_op,
  output logic              q_ready,
  input  logic              pop,
  output zhu_pkg::zhu_head_t head
);
  import zhu_pkg::*;

  zhu_op_t                  slots [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0]      wp;
  logic [QUEUE_PW-1:0]      rp;
  logic [QUEUE_PW:0]        count;
  logic                     do_push;
  logic                     do_pop;

  assign q_ready    = count != (QUEUE_PW+1)'(QUEUE_DEPTH);
  assign head.valid = count != '0;
  assign head.op    = slots[rp];
  assign do_push    = push && q_ready;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) wp <= wp + 1'b1;
      if (do_pop)  rp <= rp + 1'b1;
      count <= count + (QUEUE_PW+1)'(do_push) - (QUEUE_PW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wp] <= push_op;
  end

endmodule

// ===== src/zhu_back.sv =====
// Back part: salt memory, read sequencer, key accumulators and output buffer.
module zhu_back #(
  parameter int SQUARES     = 32,
  parameter int PIECE_TYPES = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  zhu_pkg::zhu_head_t head,
  output logic               pop,
  zhu_result_if.source       result
);
  import zhu_pkg::*;

  localparam int DEPTH = SQUARES * PIECE_TYPES;
  localparam int AW    = $clog2(DEPTH);

  logic [63:0] salt_low_store  [DEPTH];
  logic [63:0] salt_high_store [DEPTH];

  // issue stage
  logic [1:0]         step;
  logic               needs_res;
  logic               last_beat;
  logic               credit_ok;
  logic               go;
  logic               reserve;
  logic [SALT_AW-1:0] rd_addr;
  logic [2:0]         credit_sum;

  // read-return stage
  logic        b_valid;
  logic        b_rd;
  logic        b_first;
  logic        b_last;
  logic        b_move;
  logic        b_emit;
  logic [63:0] b_key_lo;
  logic [63:0] b_key_hi;
  logic [63:0] rd_lo;
  logic [63:0] rd_hi;
  logic [63:0] data_lo;
  logic [63:0] data_hi;
  logic [63:0] mv_lo;
  logic [63:0] mv_hi;
  logic [63:0] sc_lo;
  logic [63:0] sc_hi;
  logic [63:0] acc_lo;
  logic [63:0] acc_hi;
  logic [63:0] scan_low;
  logic [63:0] scan_high;
  logic        res_push;

  // output buffer
  logic        ob_kind [OUT_DEPTH];
  logic [63:0] ob_lo   [OUT_DEPTH];
  logic [63:0] ob_hi   [OUT_DEPTH];
  logic        ob_wp;
  logic        ob_rp;
  logic [1:0]  out_cnt;
  logic [1:0]  pend;
  logic        out_pop;

  assign needs_res = head.op.emit;
  assign last_beat = (head.op.nrd == 2'd0) || (step == head.op.nrd - 2'd1);
  // results in the buffer plus results reserved by items in flight
  assign credit_sum = 3'(out_cnt) - 3'(out_pop) + 3'(pend);
  assign credit_ok  = credit_sum < 3'(OUT_DEPTH);
  assign go         = head.valid && ((step != 2'd0) || !needs_res || credit_ok);
  assign pop        = go && last_beat;
  assign reserve    = go && (step == 2'd0) && needs_res;

  always_comb begin
    case (step)
      2'd0:    rd_addr = head.op.addr[0];
      2'd1:    rd_addr = head.op.addr[1];
      default: rd_addr = head.op.addr[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 2'd0;
    end else if (go) begin
      step <= last_beat ? 2'd0 : step + 2'd1;
    end
  end

  // single-port salt memory: one write or one read per cycle
  always_ff @(posedge clk) begin
    if (go && head.op.act == OP_LOAD) begin
      salt_low_store[head.op.addr[0][AW-1:0]]  <= head.op.dlo;
      salt_high_store[head.op.addr[0][AW-1:0]] <= head.op.dhi;
    end else if (go) begin
      rd_lo <= salt_low_store[rd_addr[AW-1:0]];
      rd_hi <= salt_high_store[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= go && head.op.act != OP_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      b_rd     <= step < head.op.nrd;
      b_first  <= step == 2'd0;
      b_last   <= last_beat;
      b_move   <= head.op.act == OP_MOVE;
      b_emit   <= needs_res;
      b_key_lo <= head.op.dlo;
      b_key_hi <= head.op.dhi;
    end
  end

  assign data_lo  = b_rd ? rd_lo : '0;
  assign data_hi  = b_rd ? rd_hi : '0;
  assign mv_lo    = (b_first ? b_key_lo : acc_lo) ^ data_lo;
  assign mv_hi    = (b_first ? b_key_hi : acc_hi) ^ data_hi;
  assign sc_lo    = scan_low ^ data_lo;
  assign sc_hi    = scan_high ^ data_hi;
  assign res_push = b_valid && b_last && b_emit;

  always_ff @(posedge clk) begin
    if (b_valid && b_move) begin
      acc_lo <= mv_lo;
      acc_hi <= mv_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_low  <= '0;
      scan_high <= '0;
    end else if (b_valid && !b_move) begin
      scan_low  <= (b_last && b_emit) ? '0 : sc_lo;
      scan_high <= (b_last && b_emit) ? '0 : sc_hi;
    end
  end

  assign result.valid    = out_cnt != 2'd0;
  assign result.kind     = ob_kind[ob_rp];
  assign result.key_low  = ob_lo[ob_rp];
  assign result.key_high = ob_hi[ob_rp];
  assign out_pop         = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_wp   <= 1'b0;
      ob_rp   <= 1'b0;
      out_cnt <= 2'd0;
      pend    <= 2'd0;
    end else begin
      if (res_push) ob_wp <= ob_wp + 1'b1;
      if (out_pop)  ob_rp <= ob_rp + 1'b1;
      out_cnt <= out_cnt + 2'(res_push) - 2'(out_pop);
      pend    <= pend + 2'(reserve) - 2'(res_push);
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      ob_kind[ob_wp] <= b_move ? KIND_MOVE : KIND_BOARD;
      ob_lo[ob_wp]   <= b_move ? mv_lo : sc_lo;
      ob_hi[ob_wp]   <= b_move ? mv_hi : sc_hi;
    end
  end

  // reserved plus buffered results never exceed the buffer
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    (3'(out_cnt) + 3'(pend)) <= 3'(OUT_DEPTH))
    else $error("result credit overflow");

  // a result is only written where there is room for it
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (out_cnt != 2'(OUT_DEPTH)) || out_pop)
    else $error("result written into full buffer");

  // reads of one item are issued in consecutive cycles
  a_beats_contiguous: assert property (@(posedge clk) disable iff (rst)
    (b_valid && !b_first) |-> $past(b_valid))
    else $error("gap inside a multi-read item");

  // a result push always consumes a reservation
  a_push_reserved: assert property (@(posedge clk) disable iff (rst)
    res_push |-> pend != 2'd0)
    else $error("result pushed without reservation");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step != 2'd3)
    else $error("read step out of range");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the 128-bit Zobrist hash update block.
module tb_top;
  import zhu_pkg::*;

  localparam int SQUARES     = 32;
  localparam int PIECE_TYPES = 15;
  localparam int SALT_DEPTH  = SQUARES * PIECE_TYPES;
  localparam logic [3:0] COVER_PIECE = 4'(PIECE_TYPES - 1);
  localparam logic [4:0] LAST_SQUARE = 5'(SQUARES - 1);

  // Action code 3 has no meaning; the block must swallow it silently.
  localparam logic [1:0] ACTION_NONE = 2'd3;

  // Move flavors used by the stimulus generator.
  localparam int MOVE_FLIP    = 0;
  localparam int MOVE_PLAIN   = 1;
  localparam int MOVE_CAPTURE = 2;

  // Idle styles: none, uniform random gaps, mostly none with rare long gaps.
  localparam int IDLE_NONE   = 0;
  localparam int IDLE_RANDOM = 1;
  localparam int IDLE_BURSTY = 2;

  localparam int RANDOM_ITEMS = 500;

  typedef struct {
    logic [1:0]  action;
    logic [8:0]  salt_index;
    logic [63:0] data_low;
    logic [63:0] data_high;
    logic [4:0]  from_square;
    logic [4:0]  to_square;
    logic [3:0]  from_piece;
    logic [3:0]  to_piece;
    logic        empty_flag;
    logic [3:0]  revealed_piece;
    bit          drain;          // hold this beat until all keys are back
  } hash_item_t;

  typedef struct packed {
    logic         kind;
    logic [127:0] key;           // {high, low}
  } hash_key_t;

  logic clk;
  logic rst;

  zhu_item_if   item_ch ();
  zhu_result_if res_ch ();

  zobrist_hash_update #(
    .SQUARES     (SQUARES),
    .PIECE_TYPES (PIECE_TYPES)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch)
  );

  // Predictor state: our own copy of the salt table and the running scan key.
  logic [127:0] salt_tab [SALT_DEPTH];
  logic [127:0] scan_key;

  hash_item_t pend_q [$];        // beats still to be sent
  hash_key_t  key_q [$];         // keys the block still owes us
  hash_item_t cur;

  bit in_fire;
  bit out_fire;
  int hold_cnt;
  int stall_cnt;
  int src_mode;
  int snk_mode;
  int sent_cnt;
  int rcv_cnt;
  int errors;
  int n_load, n_scan, n_move, n_none;
  int n_board_keys, n_move_keys;

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------

  function automatic int idle_cycles(int mode);
    case (mode)
      IDLE_NONE:   return 0;
      IDLE_RANDOM: return $urandom_range(0, 16);
      default:     return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
    endcase
  endfunction

  // 64-bit word with the all-zero and all-one extremes showing up now and then.
  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly legal piece types; 15 is out of range and must read as zero salt.
  function automatic logic [3:0] rand_piece();
    if ($urandom_range(0, 15) == 0) return 4'hF;
    return 4'($urandom_range(0, PIECE_TYPES - 1));
  endfunction

  // Fully random beat; the generators override what matters for each action.
  function automatic hash_item_t rand_item(logic [1:0] action);
    hash_item_t it;
    it.action         = action;
    it.salt_index     = 9'($urandom);
    it.data_low       = rand_word();
    it.data_high      = rand_word();
    it.from_square    = 5'($urandom);
    it.to_square      = 5'($urandom);
    it.from_piece     = 4'($urandom);
    it.to_piece       = 4'($urandom);
    it.empty_flag     = 1'($urandom);
    it.revealed_piece = 4'($urandom);
    it.drain          = 1'b0;
    return it;
  endfunction

  function automatic hash_item_t mk_item(logic [1:0] action, logic [8:0] sidx,
                                         logic [63:0] lo, logic [63:0] hi,
                                         logic [4:0] fsq, logic [4:0] tsq,
                                         logic [3:0] fpc, logic [3:0] tpc,
                                         logic empty, logic [3:0] rpc);
    hash_item_t it;
    it = '{action, sidx, lo, hi, fsq, tsq, fpc, tpc, empty, rpc, 1'b0};
    return it;
  endfunction

  // Salt lookup; squares or pieces off the table contribute nothing.
  function automatic logic [127:0] salt_of(logic [4:0] sq, logic [3:0] pc);
    if (int'(sq) >= SQUARES || int'(pc) >= PIECE_TYPES) return '0;
    return salt_tab[int'(sq) * PIECE_TYPES + int'(pc)];
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor: applies one accepted beat and queues the key it should produce.
  // ---------------------------------------------------------------------------
  task automatic predict_hash(input hash_item_t it);
    logic [127:0] k;
    case (it.action)
      ACTION_LOAD: begin
        n_load++;
        // Indexes past the table are dropped by the block.
        if (int'(it.salt_index) < SALT_DEPTH)
          salt_tab[it.salt_index] = {it.data_high, it.data_low};
      end
      ACTION_SCAN: begin
        n_scan++;
        if (!it.empty_flag) scan_key ^= salt_of(it.from_square, it.from_piece);
        // Only the last square closes the scan: emit and restart from zero.
        if (it.from_square == LAST_SQUARE) begin
          key_q.push_back({KIND_BOARD, scan_key});
          scan_key = '0;
        end
      end
      ACTION_MOVE: begin
        n_move++;
        k = {it.data_high, it.data_low};
        if (it.from_square == it.to_square) begin
          // Flip: covered piece leaves, revealed piece appears on the same square.
          k ^= salt_of(it.from_square, COVER_PIECE) ^ salt_of(it.from_square, it.revealed_piece);
        end else begin
          k ^= salt_of(it.from_square, it.from_piece) ^ salt_of(it.to_square, it.from_piece);
          // Capture also takes the victim off the destination.
          if (!it.empty_flag) k ^= salt_of(it.to_square, it.to_piece);
        end
        key_q.push_back({KIND_MOVE, k});
      end
      default: n_none++;
    endcase
  endtask

  task automatic check_result();
    hash_key_t want;
    if (key_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("[%0t] unexpected result: kind %0b key %h_%h", $realtime,
                 res_ch.kind, res_ch.key_high, res_ch.key_low);
      return;
    end
    want = key_q.pop_front();
    if (want.kind == KIND_BOARD) n_board_keys++;
    else n_move_keys++;
    if (res_ch.kind !== want.kind || res_ch.key_low !== want.key[63:0] ||
        res_ch.key_high !== want.key[127:64]) begin
      errors++;
      if (errors <= 10)
        $display("[%0t] key mismatch: expected kind %0b key %h_%h, got kind %0b key %h_%h",
                 $realtime, want.kind, want.key[127:64], want.key[63:0],
                 res_ch.kind, res_ch.key_high, res_ch.key_low);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: both channels are sampled at the rising edge in one process, so
  // the expectation of a beat is always queued before its key can be checked.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    in_fire  = !rst && item_ch.valid && item_ch.ready;
    out_fire = !rst && res_ch.valid && res_ch.ready;
    if (in_fire)
      predict_hash(mk_item(item_ch.action, item_ch.salt_index, item_ch.data_low,
                           item_ch.data_high, item_ch.from_square, item_ch.to_square,
                           item_ch.from_piece, item_ch.to_piece, item_ch.empty_flag,
                           item_ch.revealed_piece));
    if (out_fire) check_result();
  end

  // ---------------------------------------------------------------------------
  // Item driver: changes the channel at the falling edge only. valid and the
  // payload hold until the beat is taken; then an idle gap drawn per beat may
  // follow. A beat marked drain waits for every outstanding key first.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst) begin
      if (!item_ch.valid || in_fire) begin
        if (hold_cnt > 0) begin
          hold_cnt--;
          item_ch.valid <= 1'b0;
        end else if (pend_q.size() == 0 || (pend_q[0].drain && key_q.size() != 0)) begin
          item_ch.valid <= 1'b0;
        end else begin
          cur = pend_q.pop_front();
          item_ch.action         <= cur.action;
          item_ch.salt_index     <= cur.salt_index;
          item_ch.data_low       <= cur.data_low;
          item_ch.data_high      <= cur.data_high;
          item_ch.from_square    <= cur.from_square;
          item_ch.to_square      <= cur.to_square;
          item_ch.from_piece     <= cur.from_piece;
          item_ch.to_piece       <= cur.to_piece;
          item_ch.empty_flag     <= cur.empty_flag;
          item_ch.revealed_piece <= cur.revealed_piece;
          item_ch.valid          <= 1'b1;
          sent_cnt++;
          // Switch idle style now and then so bursts and sparse traffic both occur.
          if (sent_cnt % 64 == 0) src_mode = $urandom_range(IDLE_NONE, IDLE_BURSTY);
          hold_cnt = idle_cycles(src_mode);
        end
      end
    end
  end

  // Result sink: after each taken key, ready may drop for a drawn stall.
  always @(negedge clk) begin
    if (!rst) begin
      if (out_fire) begin
        rcv_cnt++;
        if (rcv_cnt % 16 == 0) snk_mode = $urandom_range(IDLE_NONE, IDLE_BURSTY);
        stall_cnt = idle_cycles(snk_mode);
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // One complete board scan, squares in order, random occupancy.
  task automatic add_board_scan();
    hash_item_t it;
    for (int sq = 0; sq < SQUARES; sq++) begin
      it             = rand_item(ACTION_SCAN);
      it.from_square = 5'(sq);
      it.from_piece  = rand_piece();
      it.empty_flag  = ($urandom_range(0, 2) == 0);
      pend_q.push_back(it);
    end
  endtask

  task automatic add_move(int flavor);
    hash_item_t it;
    it             = rand_item(ACTION_MOVE);
    it.from_square = 5'($urandom_range(0, SQUARES - 1));
    it.from_piece  = rand_piece();
    it.to_piece    = rand_piece();
    it.revealed_piece = rand_piece();
    if (flavor == MOVE_FLIP) begin
      it.to_square = it.from_square;
    end else begin
      it.to_square  = 5'((int'(it.from_square) + $urandom_range(1, SQUARES - 1)) % SQUARES);
      it.empty_flag = (flavor == MOVE_PLAIN);
    end
    pend_q.push_back(it);
  endtask

  task automatic build_stimulus();
    hash_item_t it;
    int cnt;
    int len;

    // Fill the whole salt table first, so no beat ever reads an unloaded entry.
    for (int i = 0; i < SALT_DEPTH; i++) begin
      it            = rand_item(ACTION_LOAD);
      it.salt_index = 9'(i);
      pend_q.push_back(it);
    end

    // Directed: table corners, dropped loads, scan corner cases, each move type.
    pend_q.push_back(mk_item(ACTION_LOAD, 9'd0, '1, '0, 5'd0, 5'd0, 4'd0, 4'd0, 1'b0, 4'd0));
    pend_q.push_back(mk_item(ACTION_LOAD, 9'(SALT_DEPTH - 1), '0, '1, '1, '1, '1, '1, 1'b1, '1));
    pend_q.push_back(mk_item(ACTION_LOAD, 9'(SALT_DEPTH), '1, '1, 5'd0, 5'd0, 4'd0, 4'd0,
                             1'b0, 4'd0));
    pend_q.push_back(mk_item(ACTION_LOAD, '1, '1, '1, '1, '1, '1, '1, 1'b1, '1));
    pend_q.push_back(mk_item(ACTION_SCAN, 9'd0, '0, '0, 5'd0, 5'd0, 4'd0, 4'd0, 1'b0, 4'd0));
    pend_q.push_back(mk_item(ACTION_SCAN, 9'd0, '0, '0, 5'd5, 5'd0, 4'd3, 4'd0, 1'b1, 4'd0));
    pend_q.push_back(mk_item(ACTION_SCAN, 9'd0, '1, '1, 5'd7, 5'd0, 4'hF, 4'd0, 1'b0, 4'd0));
    pend_q.push_back(mk_item(ACTION_SCAN, 9'd0, '0, '0, LAST_SQUARE, 5'd0, COVER_PIECE, 4'd0,
                             1'b0, 4'd0));
    // Back-to-back closing squares: the second must emit the cleared key.
    pend_q.push_back(mk_item(ACTION_SCAN, 9'd0, '0, '0, LAST_SQUARE, 5'd0, 4'd0, 4'd0,
                             1'b1, 4'd0));
    pend_q.push_back(mk_item(ACTION_SCAN, 9'd0, '0, '0, LAST_SQUARE, 5'd0, 4'hF, 4'd0,
                             1'b0, 4'd0));
    pend_q.push_back(mk_item(ACTION_MOVE, 9'd0, '0, '0, 5'd0, 5'd0, COVER_PIECE, 4'd0,
                             1'b1, 4'd0));
    pend_q.push_back(mk_item(ACTION_MOVE, 9'd0, '1, '1, LAST_SQUARE, LAST_SQUARE, 4'd0, 4'd0,
                             1'b0, COVER_PIECE));
    pend_q.push_back(mk_item(ACTION_MOVE, 9'd0, '1, '0, 5'd9, 5'd9, 4'd0, 4'd0, 1'b1, 4'hF));
    pend_q.push_back(mk_item(ACTION_MOVE, 9'd0, '0, '1, 5'd0, LAST_SQUARE, COVER_PIECE, 4'd0,
                             1'b1, 4'd0));
    pend_q.push_back(mk_item(ACTION_MOVE, 9'd0, '0, '0, LAST_SQUARE, 5'd0, 4'd0, COVER_PIECE,
                             1'b0, 4'd0));
    pend_q.push_back(mk_item(ACTION_MOVE, 9'd0, '1, '1, 5'd3, 5'd4, 4'd2, 4'hF, 1'b0, 4'd0));
    pend_q.push_back(mk_item(ACTION_MOVE, 9'd0, '0, '0, 5'd4, 5'd3, 4'hF, 4'd6, 1'b0, 4'd0));
    pend_q.push_back(mk_item(ACTION_MOVE, 9'd0, '0, '0, 5'd4, 5'd3, 4'hF, 4'd6, 1'b1, 4'd0));
    pend_q.push_back(mk_item(ACTION_NONE, '1, '1, '1, '1, '1, '1, '1, 1'b1, '1));
    pend_q.push_back(mk_item(ACTION_NONE, '0, '0, '0, LAST_SQUARE, 5'd0, 4'd0, 4'd0,
                             1'b0, 4'd0));

    // Random part: mostly whole board scans and legal moves with random content,
    // salt rewrites in between, plus partial scans and dead action codes as noise.
    cnt = 0;
    while (cnt < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          add_board_scan();
          cnt += SQUARES;
        end
        3: begin
          len = $urandom_range(1, 8);
          for (int i = 0; i < len; i++) begin
            it             = rand_item(ACTION_SCAN);
            it.from_piece  = rand_piece();
            pend_q.push_back(it);
          end
          cnt += len;
        end
        4, 5, 6, 7: begin
          it = rand_item(ACTION_LOAD);
          if ($urandom_range(0, 9) != 0)
            it.salt_index = 9'($urandom_range(0, SALT_DEPTH - 1));
          pend_q.push_back(it);
          cnt++;
        end
        8: pend_q.push_back(rand_item(ACTION_NONE));
        default: begin
          add_move($urandom_range(MOVE_FLIP, MOVE_CAPTURE));
          cnt++;
        end
      endcase
      // Occasionally hold the sender until the block has drained.
      if ($urandom_range(0, 49) == 0) pend_q[$].drain = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Reset, run and end of test
  // ---------------------------------------------------------------------------
  initial begin
    clk      = 1'b0;
    rst      = 1'b1;
    src_mode = IDLE_RANDOM;
    snk_mode = IDLE_NONE;
    scan_key = '0;
    for (int i = 0; i < SALT_DEPTH; i++) salt_tab[i] = '0;
    item_ch.valid          = 1'b0;
    item_ch.action         = ACTION_LOAD;
    item_ch.salt_index     = '0;
    item_ch.data_low       = '0;
    item_ch.data_high      = '0;
    item_ch.from_square    = '0;
    item_ch.to_square      = '0;
    item_ch.from_piece     = '0;
    item_ch.to_piece       = '0;
    item_ch.empty_flag     = 1'b0;
    item_ch.revealed_piece = '0;
    res_ch.ready           = 1'b0;

    build_stimulus();
    // The first random-phase style drain is forced here: the directed beats
    // must all come back before random traffic starts.
    pend_q[SALT_DEPTH + 20].drain = 1'b1;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (pend_q.size() == 0 && !item_ch.valid);
    wait (key_q.size() == 0);
    // Give a stray extra key time to show up.
    repeat (24) @(posedge clk);

    $display("covered %0d salt loads, %0d board squares, %0d moves, %0d dead actions",
             n_load, n_scan, n_move, n_none);
    $display("checked %0d board hashes and %0d move keys, %0d mismatches",
             n_board_keys, n_move_keys, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
